/* hw/rtl/ghi_pkg.sv */
package ghi_pkg;

  // Calibration set size and the fixed point scale of the zero-rate offset.
  localparam int CAL_SAMPLES   = 16;
  localparam int OFFSET_SCALE  = 16;
  localparam int OFFSET_SHIFT  = $clog2(OFFSET_SCALE);

  // Field and register widths.
  localparam int GYRO_W = 16;
  localparam int TIME_W = 32;
  localparam int HEAD_W = 27;
  localparam int DB_W   = 20;
  localparam int STEP_W = 8;
  localparam int CFG_W  = 20;

  // Calibration accumulator, sample counter and offset widths.
  localparam int CNT_W = $clog2(CAL_SAMPLES + 1);
  localparam int SUM_W = GYRO_W + $clog2(CAL_SAMPLES) + 1;
  localparam int OFF_W = GYRO_W + OFFSET_SHIFT + 1;

  // Rate in 1/16 LSB, its product with the step, and the unwrapped heading sum.
  localparam int RATE_W = OFF_W + 1;
  localparam int PROD_W = RATE_W + STEP_W + 1;
  localparam int HSUM_W = PROD_W + 1;

  // One full turn in 1/262144 degree.
  localparam int TURN_UNITS = 94371840;

  // Register reset values.
  localparam logic [DB_W-1:0]   DEADBAND_RST = DB_W'(105);
  localparam logic [STEP_W-1:0] MAX_STEP_RST = STEP_W'(200);

  typedef enum logic [1:0] {
    CMD_HEADING = 2'd0,
    CMD_CAL     = 2'd1,
    CMD_RESET   = 2'd2
  } cmd_e;

  typedef enum logic {
    REG_DEADBAND = 1'b0,
    REG_MAX_STEP = 1'b1
  } reg_e;

  // Heading increment terms handed from the rate logic to the wrap logic.
  typedef struct packed {
    logic signed [RATE_W-1:0] rate;
    logic [STEP_W-1:0]        step;
  } incr_t;

endpackage

/* hw/rtl/gyro_heading_integrator.sv */
// An accepted word waits in the input register until the output is free.
// Throughput: one word per cycle while results are taken; the input register and the
// heading state update in the same cycle, so the next word follows directly behind.
// Reset (rst_ni low, asynchronous): heading, last time, calibration sum, count,
// offset and calibrated flag clear; deadband returns to 105 and max step to 200 ms.
module gyro_heading_integrator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic                              cfg_index_i,
  input  logic [ghi_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        command_i,
  input  logic signed [ghi_pkg::GYRO_W-1:0] gyro_z_i,
  input  logic [ghi_pkg::TIME_W-1:0]        time_ms_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [ghi_pkg::HEAD_W-1:0]        heading_o,
  output logic                              calibrated_o
);
  import ghi_pkg::*;

  logic                     in_valid_q;
  logic [1:0]               cmd_q;
  logic signed [GYRO_W-1:0] gyro_z_q;
  logic [TIME_W-1:0]        time_q;
  logic                     out_valid_q;

  logic [DB_W-1:0]          deadband_q;
  logic [STEP_W-1:0]        max_step_q;

  logic [HEAD_W-1:0]        heading_q;
  logic [TIME_W-1:0]        last_time_q;
  logic signed [SUM_W-1:0]  cal_sum_q;
  logic [CNT_W-1:0]         cal_count_q;
  logic signed [OFF_W-1:0]  zero_offset_q;
  logic                     cal_done_q;

  logic                     advance;
  logic signed [SUM_W-1:0]  cal_sum_d;
  logic signed [OFF_W-1:0]  zero_offset_d;
  logic                     cal_last;
  incr_t                    incr;
  logic [HEAD_W-1:0]        heading_d;

  // The held word is processed once the result slot is free or being emptied.
  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign cfg_ready_o = 1'b1;

  assign out_valid_o  = out_valid_q;
  assign heading_o    = heading_q;
  assign calibrated_o = cal_done_q;

  // Calibration sum and the offset it gives when the set is complete.
  assign cal_sum_d     = cal_sum_q + {{(SUM_W-GYRO_W){gyro_z_q[GYRO_W-1]}}, gyro_z_q};
  assign cal_last      = (cal_count_q == CNT_W'(CAL_SAMPLES - 1));
  assign zero_offset_d = OFF_W'($signed({cal_sum_d, {OFFSET_SHIFT{1'b0}}}) / CAL_SAMPLES);

  ghi_rate u_rate (
    .gyro_z_i      (gyro_z_q),
    .time_ms_i     (time_q),
    .last_time_i   (last_time_q),
    .zero_offset_i (zero_offset_q),
    .deadband_i    (deadband_q),
    .max_step_i    (max_step_q),
    .incr_o        (incr)
  );

  ghi_wrap u_wrap (
    .heading_i (heading_q),
    .incr_i    (incr),
    .heading_o (heading_d)
  );

  // Input register and result handshake.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Input payload.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q    <= command_i;
      gyro_z_q <= gyro_z_i;
      time_q   <= time_ms_i;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadband_q <= DEADBAND_RST;
      max_step_q <= MAX_STEP_RST;
    end else if (cfg_valid_i) begin
      unique case (reg_e'(cfg_index_i))
        REG_DEADBAND: deadband_q <= cfg_data_i[DB_W-1:0];
        REG_MAX_STEP: max_step_q <= cfg_data_i[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Heading and calibration state, updated by the word in the input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heading_q     <= '0;
      last_time_q   <= '0;
      cal_sum_q     <= '0;
      cal_count_q   <= '0;
      zero_offset_q <= '0;
      cal_done_q    <= 1'b0;
    end else if (advance) begin
      unique case (cmd_q)
        CMD_HEADING: begin
          if (cal_done_q) begin
            heading_q   <= heading_d;
            last_time_q <= time_q;
          end
        end
        CMD_CAL: begin
          if (cal_last) begin
            zero_offset_q <= zero_offset_d;
            cal_done_q    <= 1'b1;
            cal_sum_q     <= '0;
            cal_count_q   <= '0;
            last_time_q   <= time_q;
          end else begin
            cal_sum_q   <= cal_sum_d;
            cal_count_q <= cal_count_q + CNT_W'(1);
          end
        end
        CMD_RESET: begin
          heading_q   <= '0;
          last_time_q <= time_q;
        end
        default: ;
      endcase
    end
  end

endmodule

/* hw/rtl/ghi_rate.sv */
module ghi_rate (
  input  logic signed [ghi_pkg::GYRO_W-1:0] gyro_z_i,
  input  logic [ghi_pkg::TIME_W-1:0]        time_ms_i,
  input  logic [ghi_pkg::TIME_W-1:0]        last_time_i,
  input  logic signed [ghi_pkg::OFF_W-1:0]  zero_offset_i,
  input  logic [ghi_pkg::DB_W-1:0]          deadband_i,
  input  logic [ghi_pkg::STEP_W-1:0]        max_step_i,
  output ghi_pkg::incr_t                    incr_o
);
  import ghi_pkg::*;

  logic signed [RATE_W-1:0] gyro_scaled;
  logic signed [RATE_W-1:0] rate_raw;
  logic [RATE_W-1:0]        rate_mag;
  logic [TIME_W-1:0]        delta;

  // Bias-free rate, negated, in 1/16 LSB.
  assign gyro_scaled = {{(RATE_W-GYRO_W-OFFSET_SHIFT){gyro_z_i[GYRO_W-1]}}, gyro_z_i,
                        {OFFSET_SHIFT{1'b0}}};
  assign rate_raw    = {{(RATE_W-OFF_W){zero_offset_i[OFF_W-1]}}, zero_offset_i} - gyro_scaled;
  assign rate_mag    = rate_raw[RATE_W-1] ? RATE_W'(-rate_raw) : RATE_W'(rate_raw);

  // Time step since the stored timestamp, limited to the configured maximum.
  assign delta = time_ms_i - last_time_i;

  always_comb begin
    if (rate_mag < {{(RATE_W-DB_W){1'b0}}, deadband_i}) begin
      incr_o.rate = '0;
    end else begin
      incr_o.rate = rate_raw;
    end
    if (last_time_i == '0) begin
      incr_o.step = '0;
    end else if (delta > {{(TIME_W-STEP_W){1'b0}}, max_step_i}) begin
      incr_o.step = max_step_i;
    end else begin
      incr_o.step = delta[STEP_W-1:0];
    end
  end

endmodule

/* hw/rtl/ghi_wrap.sv */
module ghi_wrap (
  input  logic [ghi_pkg::HEAD_W-1:0] heading_i,
  input  ghi_pkg::incr_t             incr_i,
  output logic [ghi_pkg::HEAD_W-1:0] heading_o
);
  import ghi_pkg::*;

  localparam int NCAND = 7;
  localparam int KOFF  = 3;

  logic signed [PROD_W-1:0] prod;
  logic signed [HSUM_W-1:0] hsum;
  logic signed [HSUM_W-1:0] cand [NCAND];

  // Heading change for this sample, then the unwrapped sum.
  assign prod = PROD_W'(incr_i.rate * $signed({1'b0, incr_i.step}));
  assign hsum = $signed({{(HSUM_W-HEAD_W){1'b0}}, heading_i})
              + {{(HSUM_W-PROD_W){prod[PROD_W-1]}}, prod};

  // The sum lies within three turns either side, so shift it by every whole
  // number of turns in that span and keep the one that lands inside a turn.
  always_comb begin
    heading_o = '0;
    for (int i = 0; i < NCAND; i++) begin
      cand[i] = hsum - HSUM_W'(TURN_UNITS * (i - KOFF));
      if (!cand[i][HSUM_W-1] && (cand[i] < HSUM_W'(TURN_UNITS))) begin
        heading_o = cand[i][HEAD_W-1:0];
      end
    end
  end

endmodule

/* hw/rtl/ghi_checker.sv */
module ghi_prop_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [ghi_pkg::HEAD_W-1:0] heading_o,
  input logic                       calibrated_o
);
  import ghi_pkg::*;

  // A result word that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result word dropped before it was taken");

  // A stalled result word keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(heading_o) && $stable(calibrated_o))
    else $error("stalled result word changed");

  // The heading always lies within one turn.
  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> heading_o < HEAD_W'(TURN_UNITS))
    else $error("heading outside one turn");

  // Calibration, once complete, is never lost.
  a_cal_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    calibrated_o |=> calibrated_o)
    else $error("calibrated flag cleared");

endmodule

bind gyro_heading_integrator ghi_prop_checker u_ghi_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .heading_o    (heading_o),
  .calibrated_o (calibrated_o)
);

/* tb/ghi_checker.sv */
`timescale 1ns / 100ps

module ghi_checker
  import ghi_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  input  logic                     cfg_ready_i,
  input  logic                     cfg_index_i,
  input  logic [CFG_W-1:0]         cfg_data_i,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic [1:0]               command_i,
  input  logic signed [GYRO_W-1:0] gyro_z_i,
  input  logic [TIME_W-1:0]        time_ms_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic [HEAD_W-1:0]        heading_i,
  input  logic                     calibrated_i,
  output int                       fail_count_o,
  output int                       pending_o,
  output int                       checked_o
);

  // Only the first few failures are printed to keep the log readable.
  localparam int MAX_SHOWN = 40;

  typedef struct {
    logic [HEAD_W-1:0] heading;
    logic              calibrated;
  } heading_word_t;

  // Results still owed by the block, oldest first.
  heading_word_t heading_due_q[$];

  // Shadow copy of the registers and of the integrator state.
  logic [DB_W-1:0]   deadband;
  logic [STEP_W-1:0] max_step;
  logic [TIME_W-1:0] last_time;
  longint            heading_acc;
  longint            cal_sum;
  longint            zero_offset;
  int                cal_count;
  logic              cal_done;

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    fail_count_o++;
    if (fail_count_o <= MAX_SHOWN) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  // Advance the shadow state by one input word and form the result it owes.
  task automatic apply_word(input logic [1:0] cmd, input logic signed [GYRO_W-1:0] gz,
                            input logic [TIME_W-1:0] now, output heading_word_t due);
    longint            rate;
    longint            mag;
    longint            turn_sum;
    logic [TIME_W-1:0] step;
    case (cmd)
      CMD_HEADING: begin
        if (cal_done) begin
          // Negated, bias-free rate in 1/16 LSB, zeroed inside the deadband.
          rate = zero_offset - longint'(gz) * OFFSET_SCALE;
          mag  = (rate < 0) ? -rate : rate;
          if (mag < longint'({44'd0, deadband})) begin
            rate = 0;
          end
          // A stored time of zero means there is no earlier sample.
          step = '0;
          if (last_time != '0) begin
            step = now - last_time;
            if (step > {24'd0, max_step}) begin
              step = {24'd0, max_step};
            end
          end
          last_time = now;
          turn_sum  = (heading_acc + rate * longint'({32'd0, step})) % TURN_UNITS;
          if (turn_sum < 0) begin
            turn_sum += TURN_UNITS;
          end
          heading_acc = turn_sum;
        end
      end
      CMD_CAL: begin
        cal_sum += longint'(gz);
        cal_count++;
        if (cal_count >= CAL_SAMPLES) begin
          zero_offset = (cal_sum * OFFSET_SCALE) / CAL_SAMPLES;
          cal_done    = 1'b1;
          cal_sum     = 0;
          cal_count   = 0;
          last_time   = now;
        end
      end
      CMD_RESET: begin
        heading_acc = 0;
        last_time   = now;
      end
      default: begin
        // The unused command leaves the state alone.
      end
    endcase
    due.heading    = heading_acc[HEAD_W-1:0];
    due.calibrated = cal_done;
  endtask

  // Compare one accepted result word with the oldest expectation.
  task automatic check_result();
    heading_word_t due;
    checked_o++;
    if (heading_due_q.size() == 0) begin
      fail_count_o++;
      if (fail_count_o <= MAX_SHOWN) begin
        $display("%0t ns: result word with nothing expected, heading %0d calibrated %0d",
                 $time, heading_i, calibrated_i);
      end
    end else begin
      due = heading_due_q.pop_front();
      if (heading_i !== due.heading) begin
        note_mismatch("heading", 32'(due.heading), 32'(heading_i));
      end
      if (calibrated_i !== due.calibrated) begin
        note_mismatch("calibrated", 32'(due.calibrated), 32'(calibrated_i));
      end
    end
  endtask

  // Watch all three channels at each rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    heading_word_t due;
    if (!rst_ni) begin
      deadband     = DEADBAND_RST;
      max_step     = MAX_STEP_RST;
      last_time    = '0;
      heading_acc  = 0;
      cal_sum      = 0;
      zero_offset  = 0;
      cal_count    = 0;
      cal_done     = 1'b0;
      fail_count_o = 0;
      pending_o    = 0;
      checked_o    = 0;
      heading_due_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == REG_DEADBAND) begin
          deadband = cfg_data_i[DB_W-1:0];
        end else begin
          max_step = cfg_data_i[STEP_W-1:0];
        end
      end
      if (out_valid_i && out_ready_i) begin
        check_result();
      end
      if (in_valid_i && in_ready_i) begin
        apply_word(command_i, gyro_z_i, time_ms_i, due);
        heading_due_q.push_back(due);
      end
      pending_o = heading_due_q.size();
    end
  end

endmodule

/* tb/gyro_heading_integrator_tb.sv */
`timescale 1ns / 100ps

module gyro_heading_integrator_tb
  import ghi_pkg::*;
;

  // The command field has one code beyond the defined ones.
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int         PHASE_WORDS = 110;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic                     cfg_index_i;
  logic [CFG_W-1:0]         cfg_data_i;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic [1:0]               command_i;
  logic signed [GYRO_W-1:0] gyro_z_i;
  logic [TIME_W-1:0]        time_ms_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic [HEAD_W-1:0]        heading_o;
  logic                     calibrated_o;

  int fail_count;
  int pending;
  int checked;

  // When set, neither side inserts idle cycles.
  bit                steady;
  logic [TIME_W-1:0] clock_ms;
  int                cal_base;
  int                n_words;
  int                n_heading;
  int                n_cal;
  int                n_reset;
  int                n_unused;
  int                n_settings;

  gyro_heading_integrator dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .gyro_z_i     (gyro_z_i),
    .time_ms_i    (time_ms_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .heading_o    (heading_o),
    .calibrated_o (calibrated_o)
  );

  ghi_checker heading_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .command_i    (command_i),
    .gyro_z_i     (gyro_z_i),
    .time_ms_i    (time_ms_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .heading_i    (heading_o),
    .calibrated_i (calibrated_o),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Hard limit on the run time.
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Result side: a random stall before each word, then ready until it is taken.
  initial begin
    int stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 6);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  function automatic int sat_gyro(input int v);
    if (v > 32767) begin
      return 32767;
    end
    if (v < -32768) begin
      return -32768;
    end
    return v;
  endfunction

  // Offer one input word after a random gap and hold it until it is taken.
  task automatic send_word(input logic [1:0] cmd, input int gz, input logic [TIME_W-1:0] stamp);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    gyro_z_i   <= gz[GYRO_W-1:0];
    time_ms_i  <= stamp;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    n_words++;
    case (cmd)
      CMD_HEADING: n_heading++;
      CMD_CAL:     n_cal++;
      CMD_RESET:   n_reset++;
      default:     n_unused++;
    endcase
  endtask

  // Drop valid and wait until every result word has come back.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // Write both registers back to back; the spare data bits above max step carry noise.
  task automatic set_registers(input logic [DB_W-1:0] db, input logic [STEP_W-1:0] step);
    logic [CFG_W-1:0] data [2];
    data[0] = CFG_W'(db);
    data[1] = {(CFG_W-STEP_W)'($urandom), step};
    for (int i = 0; i < 2; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= (i == 0) ? REG_DEADBAND : REG_MAX_STEP;
      cfg_data_i  <= data[i];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      @(negedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    n_settings++;
  endtask

  function automatic logic [TIME_W-1:0] next_stamp();
    case ($urandom_range(0, 32))
      0:       clock_ms = $urandom();
      1:       clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 400);
      default: clock_ms = clock_ms + $urandom_range(0, 300);
    endcase
    return clock_ms;
  endfunction

  // A full calibration set, either pinned at a rail or scattered around a small bias.
  task automatic calibrate_set();
    int spread;
    case ($urandom_range(0, 3))
      0: begin
        cal_base = -32768;
        spread   = 0;
      end
      1: begin
        cal_base = 32767;
        spread   = 0;
      end
      default: begin
        cal_base = int'($urandom_range(0, 2000)) - 1000;
        spread   = 60;
      end
    endcase
    repeat (CAL_SAMPLES) begin
      send_word(CMD_CAL, sat_gyro(cal_base + int'($urandom_range(0, 2 * spread)) - spread),
                next_stamp());
    end
  endtask

  // Heading runs: near the bias for the deadband, anywhere, at a rail, or within 2000.
  task automatic heading_run(input int len);
    int gz;
    repeat (len) begin
      case ($urandom_range(0, 4))
        0, 1:    gz = sat_gyro(cal_base + int'($urandom_range(0, 40)) - 20);
        2:       gz = int'($urandom_range(0, 65535)) - 32768;
        3:       gz = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
        default: gz = int'($urandom_range(0, 4000)) - 2000;
      endcase
      send_word(CMD_HEADING, gz, next_stamp());
    end
  endtask

  // Mostly well-formed traffic, with stray calibration words and odd timestamps mixed in.
  task automatic random_phase(input int quota);
    int start;
    int pick;
    start = n_words;
    while (n_words - start < quota) begin
      steady = ($urandom_range(0, 6) == 0);
      pick   = $urandom_range(0, 99);
      if (pick < 12) begin
        calibrate_set();
      end else if (pick < 72) begin
        heading_run($urandom_range(1, 12));
      end else if (pick < 80) begin
        send_word(CMD_RESET, int'($urandom_range(0, 65535)) - 32768,
                  ($urandom_range(0, 4) == 0) ? '0 : next_stamp());
      end else if (pick < 86) begin
        send_word(CMD_UNUSED, int'($urandom_range(0, 65535)) - 32768, $urandom());
      end else if (pick < 94) begin
        send_word(CMD_CAL, int'($urandom_range(0, 65535)) - 32768, next_stamp());
      end else begin
        send_word(CMD_HEADING, int'($urandom_range(0, 65535)) - 32768,
                  ($urandom_range(0, 1) != 0) ? '0 : $urandom());
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_DEADBAND;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    command_i   = CMD_HEADING;
    gyro_z_i    = '0;
    time_ms_i   = '0;
    steady      = 1'b0;
    clock_ms    = '0;
    cal_base    = 0;
    n_words     = 0;
    n_heading   = 0;
    n_cal       = 0;
    n_reset     = 0;
    n_unused    = 0;
    n_settings  = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed words under the reset register values.
    // A heading word before calibration and the unused command change nothing.
    send_word(CMD_HEADING, -32768, 32'h0000_1234);
    send_word(CMD_UNUSED, 32767, 32'hFFFF_FFFF);
    send_word(CMD_RESET, 0, '0);
    // A calibration set at the negative rail, ending at time zero.
    for (int i = 0; i < CAL_SAMPLES; i++) begin
      send_word(CMD_CAL, -32768, (i == CAL_SAMPLES - 1) ? '0 : TIME_W'(i * 7 + 1));
    end
    cal_base = -32768;
    // No earlier time, so the first step is zero; then a step clamped to the maximum.
    send_word(CMD_HEADING, 32767, 32'd40);
    send_word(CMD_HEADING, 32767, 32'd300);
    // A rate just inside the deadband.
    send_word(CMD_HEADING, -32763, 32'd301);
    // Clear the heading near the top of the time range, then a step across the wrap.
    send_word(CMD_RESET, 1, 32'hFFFF_FFF0);
    send_word(CMD_HEADING, 0, 32'd5);
    send_word(CMD_UNUSED, 0, '0);
    wait_idle();

    // Register extremes first, then random settings, then back to the reset values.
    set_registers('0, 8'd255);
    random_phase(PHASE_WORDS);
    wait_idle();
    set_registers('1, 8'd1);
    random_phase(PHASE_WORDS);
    wait_idle();
    set_registers(DEADBAND_RST, 8'd0);
    random_phase(PHASE_WORDS);
    for (int p = 0; p < 6; p++) begin
      wait_idle();
      set_registers((p == 0) ? DB_W'($urandom) : DB_W'($urandom_range(0, 600)),
                    STEP_W'($urandom_range(1, 255)));
      random_phase(PHASE_WORDS);
    end
    wait_idle();
    set_registers(DEADBAND_RST, MAX_STEP_RST);
    random_phase(PHASE_WORDS);

    // Drain, then allow a few cycles for any stray result word.
    wait_idle();
    repeat (8) @(posedge clk_i);
    $display("Sent %0d words: %0d heading, %0d calibration, %0d heading clear, %0d unused.",
             n_words, n_heading, n_cal, n_reset, n_unused);
    $display("Checked %0d result words over %0d register settings, %0d failures.",
             checked, n_settings, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* gyro_heading_integrator.f */
hw/rtl/ghi_pkg.sv
hw/rtl/ghi_rate.sv
hw/rtl/ghi_wrap.sv
hw/rtl/gyro_heading_integrator.sv
hw/rtl/ghi_checker.sv
tb/ghi_checker.sv
tb/gyro_heading_integrator_tb.sv
